@@ src/phlt_pkg.sv @@
// ============================================================================
// phlt_pkg
// Shared types and constants of the pulse high/low timer.
// ============================================================================
package phlt_pkg;

    // Width of the internal run counter and edge timestamps (8 to 32).
    localparam int TIME_WIDTH = 16;
    // Width of the event_time input and of every result field.
    localparam int FIELD_WIDTH = 16;

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [FIELD_WIDTH-1:0] field_t;

    typedef struct packed {
        logic   pin_level;
        field_t event_time;
    } item_t;

    typedef struct packed {
        field_t high_time;
        field_t low_time;
        field_t pulse_count;
    } result_t;

    // Brings a time value onto a result field, truncating or zero-extending.
    function automatic field_t time_to_field(input time_t t);
        return FIELD_WIDTH'(t);
    endfunction

    // Brings an input timestamp into the internal time width.
    function automatic time_t field_to_time(input field_t f);
        return TIME_WIDTH'(f);
    endfunction

endpackage

@@ src/phlt_in_stage.sv @@
// ============================================================================
// phlt_in_stage
// Input register: captures one item per transfer and holds it for the core.
// ============================================================================
module phlt_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  phlt_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output phlt_pkg::item_t item
);
    import phlt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register can refill in the same cycle its item moves on.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ src/phlt_core.sv @@
// ============================================================================
// phlt_core
// Measurement state and its per-item update.
// ============================================================================
module phlt_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              mode_wr,
    input  logic              mode_data,
    input  logic              fire,
    input  phlt_pkg::item_t   item,
    output phlt_pkg::result_t result
);
    import phlt_pkg::*;

    logic   sample_mode_reg;
    logic   level_seen_reg;
    logic   level_seen_next;
    time_t  run_reg;
    time_t  run_next;
    time_t  high_width_reg;
    time_t  high_width_next;
    time_t  low_width_reg;
    time_t  low_width_next;
    field_t pulses_reg;
    field_t pulses_next;
    time_t  stamp;
    time_t  width;

    assign stamp = field_to_time(item.event_time);
    assign width = stamp - run_reg;

    always_comb begin
        level_seen_next = level_seen_reg;
        run_next        = run_reg;
        high_width_next = high_width_reg;
        low_width_next  = low_width_reg;
        pulses_next     = pulses_reg;
        if (sample_mode_reg) begin
            if (item.pin_level == level_seen_reg) begin
                run_next = run_reg + TIME_WIDTH'(1);
            end else if (item.pin_level) begin
                low_width_next  = run_reg;
                run_next        = '0;
                level_seen_next = 1'b1;
            end else begin
                high_width_next = run_reg;
                run_next        = '0;
                level_seen_next = 1'b0;
                pulses_next     = pulses_reg + FIELD_WIDTH'(1);
            end
        end else if (item.pin_level != level_seen_reg) begin
            if (item.pin_level) begin
                low_width_next = width;
            end else begin
                high_width_next = width;
                pulses_next     = pulses_reg + FIELD_WIDTH'(1);
            end
            run_next        = stamp;
            level_seen_next = item.pin_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_mode_reg <= 1'b0;
            level_seen_reg  <= 1'b0;
            run_reg         <= '0;
            high_width_reg  <= '0;
            low_width_reg   <= '0;
            pulses_reg      <= '0;
        end else begin
            if (mode_wr) begin
                sample_mode_reg <= mode_data;
            end
            if (fire) begin
                level_seen_reg <= level_seen_next;
                run_reg        <= run_next;
                high_width_reg <= high_width_next;
                low_width_reg  <= low_width_next;
                pulses_reg     <= pulses_next;
            end
        end
    end

    assign result.high_time   = time_to_field(high_width_next);
    assign result.low_time    = time_to_field(low_width_next);
    assign result.pulse_count = pulses_next;

endmodule

@@ src/phlt_out_stage.sv @@
// ============================================================================
// phlt_out_stage
// Result register: holds one result until the downstream side takes it.
// ============================================================================
module phlt_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  phlt_pkg::result_t result,
    output logic              load_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output phlt_pkg::result_t m_result
);
    import phlt_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ready = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

@@ src/pulse_high_low_timer_top.sv @@
// ============================================================================
// pulse_high_low_timer_top
// Pin high/low width timer and pulse counter with sampled and timestamp modes.
// ============================================================================
// Path: an item passes through the input register, then the core and the result register, to m_.
// Throughput: one item per cycle while the receiver takes results without stalling.
// Up to two items are held inside (input register and result register).
// Reset (aresetn low, synchronous) clears both registers' valid flags, the
// stored level (low), run counter, widths, pulse count and sample_mode.
module pulse_high_low_timer_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write channel: bit 0 of cfg_data is sample_mode.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    // Input channel: one pin sample or edge event per transfer.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_pin_level,
    input  phlt_pkg::field_t     s_event_time,
    // Result channel: one result per input transfer.
    output logic                 m_valid,
    input  logic                 m_ready,
    output phlt_pkg::field_t     m_high_time,
    output phlt_pkg::field_t     m_low_time,
    output phlt_pkg::field_t     m_pulse_count
);
    import phlt_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    load_ready;
    logic    fire;
    result_t result;
    result_t m_result;

    // The mode register is always ready; the user must write it only while idle (unenforced).
    assign cfg_ready = 1'b1;

    assign s_item.pin_level  = s_pin_level;
    assign s_item.event_time = s_event_time;

    // An item is processed when it sits in the input register and the
    // result register is empty or is being emptied in this cycle.
    assign fire = item_valid && load_ready;

    phlt_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // The core updates its state and forms the result in the same cycle,
    // so the following item sees the updated state.
    phlt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode_wr   (cfg_valid && cfg_ready),
        .mode_data (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    phlt_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .result     (result),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_high_time   = m_result.high_time;
    assign m_low_time    = m_result.low_time;
    assign m_pulse_count = m_result.pulse_count;

endmodule

@@ src/phlt_checker.sv @@
// ============================================================================
// phlt_checker
// Port-level checks of the pulse high/low timer, bound to the top level.
// ============================================================================
module phlt_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input phlt_pkg::field_t m_high_time,
    input phlt_pkg::field_t m_low_time,
    input phlt_pkg::field_t m_pulse_count
);
    import phlt_pkg::*;

    logic       s_xfer;
    logic       m_xfer;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       seen_reg;
    field_t     last_pulses_reg;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;
    assign inflight_next = inflight_reg + {2'b00, s_xfer} - {2'b00, m_xfer};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
            seen_reg     <= 1'b0;
        end else begin
            inflight_reg <= inflight_next;
            if (m_xfer) begin
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_xfer) begin
            last_pulses_reg <= m_pulse_count;
        end
    end

    // A result held back by the receiver stays with the same values.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_high_time) &&
        $stable(m_low_time) && $stable(m_pulse_count))
        else $error("result changed while stalled");

    // Every result belongs to an earlier input transfer.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer |-> inflight_reg != 3'd0)
        else $error("result without a pending input");

    // The pulse count advances by at most one between successive results.
    a_pulse_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && seen_reg |-> m_pulse_count == last_pulses_reg ||
        m_pulse_count == last_pulses_reg + FIELD_WIDTH'(1))
        else $error("pulse count jumped");

    // No result is offered in the cycle after reset is released.
    a_reset_empty: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind pulse_high_low_timer_top phlt_checker u_phlt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_high_time   (m_high_time),
    .m_low_time    (m_low_time),
    .m_pulse_count (m_pulse_count)
);

@@ verif/tb_pulse_high_low_timer_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_pulse_high_low_timer_top
// Self-checking testbench for the pulse high/low timer and pulse counter.
// A queue-fed driver offers pin samples and edge events and predicts each
// result when its transfer happens. A monitor checks every result transfer
// against the oldest prediction. Both sides insert random gaps, and the run
// covers both modes, the mode changes between them and a run counter wrap.
// ============================================================================
module tb_pulse_high_low_timer_top;

    import phlt_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic   aclk         = 1'b0;
    logic   aresetn      = 1'b0;
    logic   cfg_valid    = 1'b0;
    logic   cfg_ready;
    logic   cfg_data     = 1'b0;
    logic   s_valid      = 1'b0;
    logic   s_ready;
    logic   s_pin_level  = 1'b0;
    field_t s_event_time = '0;
    logic   m_valid;
    logic   m_ready      = 1'b0;
    field_t m_high_time;
    field_t m_low_time;
    field_t m_pulse_count;

    always #4 aclk = ~aclk;

    pulse_high_low_timer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pin_level   (s_pin_level),
        .s_event_time  (s_event_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_high_time   (m_high_time),
        .m_low_time    (m_low_time),
        .m_pulse_count (m_pulse_count)
    );

    // ------------------------------------------------------------------------
    // Stimulus and expectation stores, and the knobs the sequence sets.
    // ------------------------------------------------------------------------
    item_t   pending_samples[$];
    result_t expected_readings[$];
    int      fail_count    = 0;
    bit      tx_idle_on    = 1'b0;
    bit      rx_idle_on    = 1'b0;
    bit      long_hold_req = 1'b0;
    // Set when the driver loads an item and cleared in the same process when
    // its transfer happens, so the idle check never misses an item in flight.
    bit      tx_busy       = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor: a private copy of the timer state and its mode register.
    // ------------------------------------------------------------------------
    logic   mode_sampled;
    logic   last_level;
    time_t  run_or_stamp;
    time_t  high_span;
    time_t  low_span;
    field_t falling_edges;

    task automatic clear_timer_model();
        mode_sampled  = 1'b0;
        last_level    = 1'b0;
        run_or_stamp  = '0;
        high_span     = '0;
        low_span      = '0;
        falling_edges = '0;
    endtask

    // Applies one accepted item to the model and queues the reading it yields.
    task automatic measure_item(input logic level, input field_t stamp_in);
        time_t   stamp;
        time_t   span;
        result_t reading;
        stamp = TIME_WIDTH'(stamp_in);
        if (mode_sampled) begin
            if (level == last_level) begin
                // Same level: the run counter simply wraps on overflow.
                run_or_stamp = run_or_stamp + TIME_WIDTH'(1);
            end else if (level) begin
                low_span     = run_or_stamp;
                run_or_stamp = '0;
                last_level   = 1'b1;
            end else begin
                high_span     = run_or_stamp;
                run_or_stamp  = '0;
                last_level    = 1'b0;
                falling_edges = falling_edges + FIELD_WIDTH'(1);
            end
        end else if (level != last_level) begin
            // Edge event: the width is the wrapped distance to the last edge.
            span = stamp - run_or_stamp;
            if (level) begin
                low_span = span;
            end else begin
                high_span     = span;
                falling_edges = falling_edges + FIELD_WIDTH'(1);
            end
            run_or_stamp = stamp;
            last_level   = level;
        end
        // An event at the stored level in timestamp mode changes nothing.
        reading.high_time   = FIELD_WIDTH'(high_span);
        reading.low_time    = FIELD_WIDTH'(low_span);
        reading.pulse_count = falling_edges;
        expected_readings.push_back(reading);
    endtask

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Items come from pending_samples; valid stays up with a stable
    // payload until the transfer, and the model is stepped at that edge.
    // ------------------------------------------------------------------------
    int    tx_gap = 0;
    item_t next_sample;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                measure_item(s_pin_level, s_event_time);
                tx_busy = 1'b0;
            end
            // The slot is free when nothing is offered or the offer just went.
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    next_sample  = pending_samples.pop_front();
                    tx_busy      = 1'b1;
                    s_valid      <= 1'b1;
                    s_pin_level  <= next_sample.pin_level;
                    s_event_time <= next_sample.event_time;
                    tx_gap       <= tx_idle_on ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Checks each result transfer and drives m_ready with random
    // stalls. A long hold-off is counted here when the sequence asks for it.
    // ------------------------------------------------------------------------
    int      rx_stall = 0;
    int      rx_hold  = 0;
    result_t oldest;

    task automatic check_field(input string name, input field_t want, input field_t got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%04h, actual 0x%04h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result transfer with no expected reading");
                    fail_count++;
                end else begin
                    oldest = expected_readings.pop_front();
                    check_field("high_time", oldest.high_time, m_high_time);
                    check_field("low_time", oldest.low_time, m_low_time);
                    check_field("pulse_count", oldest.pulse_count, m_pulse_count);
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_hold       = 300;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers.
    // ------------------------------------------------------------------------
    task automatic queue_sample(input logic level, input field_t stamp);
        item_t it;
        it.pin_level  = level;
        it.event_time = stamp;
        pending_samples.push_back(it);
    endtask

    // Returns once everything offered has come back and the pipeline has
    // settled.
    task automatic wait_drained();
        @(posedge aclk);
        while (pending_samples.size() != 0 || tx_busy || expected_readings.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // One transfer on the configuration channel; only called while idle.
    task automatic write_mode(input logic mode);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        mode_sampled = mode;
        cfg_valid <= 1'b0;
    endtask

    // Edge events with rising timestamps: mostly real toggles, some events
    // at the stored level, and now and then a jump to an arbitrary time.
    task automatic queue_edge_events(input int count);
        logic   level;
        field_t stamp;
        int     r;
        level = last_level;
        stamp = field_t'($urandom);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                level = ~level;
            if (r >= 95)
                stamp = field_t'($urandom);
            else
                stamp = stamp + field_t'($urandom_range(0, 3000));
            queue_sample(level, stamp);
        end
    endtask

    // Periodic ticks: runs of random length at one level, then the other.
    // The timestamp field carries noise, which the block must ignore here.
    task automatic queue_level_ticks(input int count);
        logic level;
        int   run;
        int   left;
        level = last_level;
        left  = count;
        while (left > 0) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 8);
            for (int i = 0; i < run && left > 0; i++) begin
                queue_sample(level, field_t'($urandom));
                left--;
            end
            level = ~level;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        clear_timer_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed timestamp events. The first edge is measured from the
        // reset value, an event at the stored level changes nothing, and
        // widths wrap across the top of the time range.
        write_mode(1'b0);
        queue_sample(1'b1, 16'h0005);
        queue_sample(1'b1, 16'h1234);
        queue_sample(1'b0, 16'hFFFF);
        queue_sample(1'b0, 16'h0000);
        queue_sample(1'b1, 16'h0003);
        queue_sample(1'b0, 16'h0003);
        queue_sample(1'b1, 16'h0002);
        queue_sample(1'b0, 16'hAAAA);
        queue_sample(1'b1, 16'h5555);
        queue_sample(1'b0, 16'hFFFD);
        wait_drained();

        // Directed ticks. The state carries over from timestamp mode, so the
        // last edge time is now read as the run count, which sits near the
        // top of its range and wraps within the first few ticks.
        write_mode(1'b1);
        queue_sample(1'b0, 16'hFFFF);
        queue_sample(1'b0, 16'h0000);
        queue_sample(1'b0, 16'h8001);
        queue_sample(1'b1, 16'h7FFE);
        queue_sample(1'b1, 16'h0000);
        queue_sample(1'b1, 16'hFFFF);
        queue_sample(1'b0, 16'h0000);
        queue_sample(1'b1, 16'h0000);
        queue_sample(1'b0, 16'hFFFF);
        wait_drained();

        // Random phases, alternating modes so each change lands on live
        // state. Gaps are off in the first, and during the second the
        // receiver holds off long enough to stall the input.
        write_mode(1'b0);
        queue_edge_events(100);
        wait_drained();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_mode(1'b1);
        queue_level_ticks(100);
        repeat (20) @(posedge aclk);
        long_hold_req = 1'b1;
        wait_drained();

        write_mode(1'b0);
        queue_edge_events(100);
        wait_drained();

        write_mode(1'b1);
        queue_level_ticks(100);
        wait_drained();

        // Leave a margin for any stray result before the verdict.
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_pulse_high_low_timer_top: PASS");
        else
            $display("tb_pulse_high_low_timer_top: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("tb_pulse_high_low_timer_top: FAIL");
        $finish;
    end

endmodule
